### src/bps_pkg.sv
// Shared types, field widths and codes of the bucketed priority sorter.
`default_nettype none

package bps_pkg;

   localparam int ID_W       = 11;
   localparam int ADDR_W     = 18;
   localparam int PRIO_W     = 8;
   localparam int WEIGHT_W   = 24;
   localparam int DIST_F_W   = 5;
   localparam int STREET_W   = 5;
   localparam int HOUSE_W    = 8;
   localparam int RANK_W     = 6;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;
   localparam int CSR_W      = 6;
   localparam int KEY_W      = PRIO_W + WEIGHT_W;
   localparam int ENTRY_W    = ID_W + KEY_W;

   localparam int DIST_LSB   = 13;
   localparam int STREET_LSB = 8;

   localparam logic [CSR_W-1:0] CSR_RESET = 6'd32;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RANK  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_SHIFT,
      ST_PLACE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                kind;
      logic [ID_W-1:0]     packet_id;
      logic [ADDR_W-1:0]   address;
      logic [PRIO_W-1:0]   prio;
      logic [WEIGHT_W-1:0] weight;
      logic [DIST_F_W-1:0] query_district;
      logic [RANK_W-1:0]   query_rank;
   } request_type;

   typedef struct packed {
      status_type          status;
      logic [ID_W-1:0]     packet_id;
      logic [DIST_F_W-1:0] district;
      logic [STREET_W-1:0] street;
      logic [HOUSE_W-1:0]  house_number;
      logic [COUNT_W-1:0]  list_count;
   } result_type;

   typedef struct packed {
      logic idle;
      logic res_valid;
   } seq_status_type;

endpackage

`default_nettype wire

### src/bps_slot_ram.sv
// Slot memory: one write port and one registered read port.
`default_nettype none

module bps_slot_ram #(
   parameter int AW    = 11,
   parameter int DEPTH = 2048
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [bps_pkg::ENTRY_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output      logic [bps_pkg::ENTRY_W-1:0] rd_data
);

   logic [bps_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [bps_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/bps_insert_seq.sv
// Request sequencer: range and fill checks, insertion shift and rank lookup.
`default_nettype none

module bps_insert_seq #(
   parameter int DISTRICTS          = 32,
   parameter int SLOTS_PER_DISTRICT = 64,
   parameter int MAX_PACKETS        = 2048
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire bps_pkg::request_type        request,
   input  wire logic [bps_pkg::CSR_W-1:0]   districts_in_use,
   input  wire logic                        res_ready,
   output      bps_pkg::seq_status_type     seq_status,
   output      bps_pkg::result_type         result
);

   localparam int DIST_W = $clog2(DISTRICTS);
   localparam int SLOT_W = $clog2(SLOTS_PER_DISTRICT);
   localparam int CNT_W  = $clog2(SLOTS_PER_DISTRICT + 1);
   localparam int TOT_W  = $clog2(MAX_PACKETS + 1);
   localparam int AW     = DIST_W + SLOT_W;
   localparam int DEPTH  = DISTRICTS * (2 ** SLOT_W);
   localparam int CMP_W  = (CNT_W > bps_pkg::RANK_W) ? CNT_W : bps_pkg::RANK_W;

   localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS_PER_DISTRICT);
   localparam logic [TOT_W-1:0] MAX_C   = TOT_W'(MAX_PACKETS);

   bps_pkg::state_type   state_ff, state_in;
   bps_pkg::request_type req_ff;
   bps_pkg::status_type  status_ff, status_in;
   logic [SLOT_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [bps_pkg::ID_W-1:0] oid_ff, oid_in;
   logic [CNT_W-1:0]     counts_ff [DISTRICTS];
   logic [CNT_W-1:0]     counts_in [DISTRICTS];
   logic [TOT_W-1:0]     total_ff, total_in;

   logic [bps_pkg::DIST_F_W-1:0] sel_dist;
   logic [DIST_W-1:0]    idx;
   logic                 in_range;
   logic [CNT_W-1:0]     cur_cnt;
   logic                 list_full;
   logic                 rank_bad;
   logic [bps_pkg::KEY_W-1:0] new_key;
   logic                 shift_go;
   logic [SLOT_W-1:0]    pos_m1, pos_m2;

   logic                        wr_en, rd_en;
   logic [AW-1:0]               wr_addr, rd_addr;
   logic [bps_pkg::ENTRY_W-1:0] wr_data, rd_data;

   bps_slot_ram #(
      .AW    (AW),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (req_ff.kind == bps_pkg::REQ_LOAD) begin
         sel_dist = req_ff.address[bps_pkg::DIST_LSB +: bps_pkg::DIST_F_W];
      end else begin
         sel_dist = req_ff.query_district;
      end
      idx       = sel_dist[DIST_W-1:0];
      in_range  = !((bps_pkg::CSR_W'(sel_dist) >= districts_in_use) ||
                    (bps_pkg::CSR_W'(sel_dist) >= bps_pkg::CSR_W'(DISTRICTS)));
      cur_cnt   = in_range ? counts_ff[idx] : '0;
      list_full = (cur_cnt >= SLOTS_C) || (total_ff >= MAX_C);
      rank_bad  = CMP_W'(req_ff.query_rank) >= CMP_W'(cur_cnt);
      new_key   = {req_ff.prio, req_ff.weight};
      shift_go  = rd_data[bps_pkg::KEY_W-1:0] < new_key;
      pos_m1    = pos_ff - SLOT_W'(1);
      pos_m2    = pos_m1 - SLOT_W'(1);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bps_pkg::ST_IDLE: begin
            if (start) begin
               state_in = bps_pkg::ST_CHECK;
            end
         end
         bps_pkg::ST_CHECK: begin
            if (!in_range) begin
               state_in = bps_pkg::ST_DONE;
            end else if (req_ff.kind == bps_pkg::REQ_LOAD) begin
               if (list_full || cur_cnt == '0) begin
                  state_in = bps_pkg::ST_DONE;
               end else begin
                  state_in = bps_pkg::ST_SHIFT;
               end
            end else if (rank_bad) begin
               state_in = bps_pkg::ST_DONE;
            end else begin
               state_in = bps_pkg::ST_READ;
            end
         end
         bps_pkg::ST_READ: begin
            state_in = bps_pkg::ST_DONE;
         end
         bps_pkg::ST_SHIFT: begin
            if (!shift_go) begin
               state_in = bps_pkg::ST_DONE;
            end else if (pos_ff == SLOT_W'(1)) begin
               state_in = bps_pkg::ST_PLACE;
            end
         end
         bps_pkg::ST_PLACE: begin
            state_in = bps_pkg::ST_DONE;
         end
         bps_pkg::ST_DONE: begin
            if (res_ready) begin
               state_in = bps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bps_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      status_in = status_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      oid_in    = oid_ff;
      total_in  = total_ff;
      counts_in = counts_ff;
      wr_en     = 1'b0;
      wr_addr   = {idx, pos_ff};
      wr_data   = {req_ff.packet_id, new_key};
      rd_en     = 1'b0;
      rd_addr   = {idx, pos_m1};
      unique case (state_ff) inside
         bps_pkg::ST_CHECK: begin
            oid_in    = '0;
            cnt_in    = cur_cnt;
            pos_in    = SLOT_W'(cur_cnt);
            status_in = bps_pkg::STATUS_OK;
            if (!in_range) begin
               status_in = bps_pkg::STATUS_RANGE;
            end else if (req_ff.kind == bps_pkg::REQ_LOAD) begin
               if (list_full) begin
                  status_in = bps_pkg::STATUS_FULL;
               end else begin
                  cnt_in         = cur_cnt + CNT_W'(1);
                  counts_in[idx] = cur_cnt + CNT_W'(1);
                  total_in       = total_ff + TOT_W'(1);
                  if (cur_cnt == '0) begin
                     wr_en   = 1'b1;
                     wr_addr = {idx, SLOT_W'(0)};
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = {idx, SLOT_W'(cur_cnt - CNT_W'(1))};
                  end
               end
            end else if (rank_bad) begin
               status_in = bps_pkg::STATUS_RANK;
            end else begin
               rd_en   = 1'b1;
               rd_addr = {idx, SLOT_W'(req_ff.query_rank)};
            end
         end
         bps_pkg::ST_READ: begin
            oid_in = rd_data[bps_pkg::ENTRY_W-1:bps_pkg::KEY_W];
         end
         bps_pkg::ST_SHIFT: begin
            wr_en = 1'b1;
            if (shift_go) begin
               wr_data = rd_data;
               pos_in  = pos_m1;
               if (pos_ff != SLOT_W'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = {idx, pos_m2};
               end
            end
         end
         bps_pkg::ST_PLACE: begin
            wr_en = 1'b1;
         end
         bps_pkg::ST_IDLE, bps_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bps_pkg::ST_IDLE;
         total_ff <= '0;
         for (int i = 0; i < DISTRICTS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         total_ff  <= total_in;
         counts_ff <= counts_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == bps_pkg::ST_IDLE) begin
         req_ff <= request;
      end
      status_ff <= status_in;
      pos_ff    <= pos_in;
      cnt_ff    <= cnt_in;
      oid_ff    <= oid_in;
   end

   always_comb begin
      seq_status.idle      = (state_ff == bps_pkg::ST_IDLE);
      seq_status.res_valid = (state_ff == bps_pkg::ST_DONE);
      result.status        = status_ff;
      result.packet_id     = oid_ff;
      result.list_count    = bps_pkg::COUNT_W'(cnt_ff);
      if (req_ff.kind == bps_pkg::REQ_LOAD) begin
         result.district     = req_ff.address[bps_pkg::DIST_LSB +: bps_pkg::DIST_F_W];
         result.street       = req_ff.address[bps_pkg::STREET_LSB +: bps_pkg::STREET_W];
         result.house_number = req_ff.address[bps_pkg::HOUSE_W-1:0];
      end else begin
         result.district     = '0;
         result.street       = '0;
         result.house_number = '0;
      end
   end

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("slot read and write hit the same address");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= MAX_C)
      else $error("packet total above limit");

   a_shift_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bps_pkg::ST_SHIFT) |-> (pos_ff != '0))
      else $error("shift step at list head");

   a_place_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bps_pkg::ST_PLACE) |-> (pos_ff == '0))
      else $error("final placement away from list head");

endmodule

`default_nettype wire

### src/bucketed_priority_sorter_top.sv
// Top level of the bucketed priority sorter: CSR, sequencer and result register.
//
// Each request gets one result. The block takes one request at a time: a load
// goes CHECK to DONE if its list is empty or it is dropped, else SHIFT (a step
// per entry moving down one slot) to DONE, or PLACE and DONE at the list head;
// a query goes CHECK to DONE, via READ when it reads a slot. The slot memory
// moves one entry per cycle through its single read and single write port,
// which sets the load time. Results sit in an output register, so the next
// request is taken while a result waits. Slot contents are not cleared at reset,
// only list counts and packet total; only slots below a count are read. The user
// writes districts_in_use only while the block is idle; the block does not check.
`default_nettype none

module bucketed_priority_sorter_top #(
   parameter int DISTRICTS          = 32,
   parameter int SLOTS_PER_DISTRICT = 64,
   parameter int MAX_PACKETS        = 2048
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic                          req_type,
   input  wire logic [bps_pkg::ID_W-1:0]      req_packet_id,
   input  wire logic [bps_pkg::ADDR_W-1:0]    req_address_bits,
   input  wire logic [bps_pkg::PRIO_W-1:0]    req_priority_req,
   input  wire logic [bps_pkg::WEIGHT_W-1:0]  req_weight,
   input  wire logic [bps_pkg::DIST_F_W-1:0]  req_query_district,
   input  wire logic [bps_pkg::RANK_W-1:0]    req_query_rank,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [bps_pkg::STATUS_W-1:0]  rsp_status,
   output      logic [bps_pkg::ID_W-1:0]      rsp_out_packet_id,
   output      logic [bps_pkg::DIST_F_W-1:0]  rsp_district,
   output      logic [bps_pkg::STREET_W-1:0]  rsp_street,
   output      logic [bps_pkg::HOUSE_W-1:0]   rsp_house_number,
   output      logic [bps_pkg::COUNT_W-1:0]   rsp_list_count,
   input  wire logic                          csr_wr_en,
   input  wire logic [bps_pkg::CSR_W-1:0]     csr_wr_data
);

   logic [bps_pkg::CSR_W-1:0] districts_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   bps_pkg::result_type       rsp_data_ff;
   bps_pkg::result_type       result;
   bps_pkg::request_type      request;
   bps_pkg::seq_status_type   seq_status;
   logic                      start;
   logic                      res_ready;
   logic                      res_take;

   assign request.kind           = req_type;
   assign request.packet_id      = req_packet_id;
   assign request.address        = req_address_bits;
   assign request.prio           = req_priority_req;
   assign request.weight         = req_weight;
   assign request.query_district = req_query_district;
   assign request.query_rank     = req_query_rank;

   assign req_ready = seq_status.idle;
   assign start     = req_valid && seq_status.idle;
   assign res_ready = !rsp_valid_ff || rsp_ready;
   assign res_take  = seq_status.res_valid && res_ready;

   bps_insert_seq #(
      .DISTRICTS          (DISTRICTS),
      .SLOTS_PER_DISTRICT (SLOTS_PER_DISTRICT),
      .MAX_PACKETS        (MAX_PACKETS)
   ) u_insert_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .request          (request),
      .districts_in_use (districts_ff),
      .res_ready        (res_ready),
      .seq_status       (seq_status),
      .result           (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         districts_ff <= bps_pkg::CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            districts_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_data_ff.status;
   assign rsp_out_packet_id = rsp_data_ff.packet_id;
   assign rsp_district      = rsp_data_ff.district;
   assign rsp_street        = rsp_data_ff.street;
   assign rsp_house_number  = rsp_data_ff.house_number;
   assign rsp_list_count    = rsp_data_ff.list_count;

endmodule

`default_nettype wire
